// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CBE_ASSERT_IMPL(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CBE_ASSERT_NEXT(label, clk, dis, ante, cons) \
    label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- sv/cbe_pkg.sv -----
package cbe_pkg;

    localparam int VALUE_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int LEN_W     = 31;
    localparam int BF_FRAC   = 15;
    localparam int PROD_W    = VALUE_W + FRAC_W + 1;
    localparam int SAT_IN_W  = 40;
    localparam int CFG_IDX_W = 3;

    typedef logic signed [VALUE_W-1:0]  t_val;
    typedef logic        [FRAC_W-1:0]   t_frac;
    typedef logic        [LEN_W-1:0]    t_len;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SAT_IN_W-1:0] t_wide;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GRAVITY_X    = 3'd0,
        CFG_GRAVITY_Y    = 3'd1,
        CFG_TIME_STEP    = 3'd2,
        CFG_WORLD_WIDTH  = 3'd3,
        CFG_WORLD_HEIGHT = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        t_val  gravity_x;
        t_val  gravity_y;
        t_frac time_step;
        t_len  world_width;
        t_len  world_height;
    } t_cfg;

    localparam t_val  RST_GRAVITY_X    = 32'sd0;
    localparam t_val  RST_GRAVITY_Y    = 32'sd642253;
    localparam t_frac RST_TIME_STEP    = 16'd1092;
    localparam t_len  RST_WORLD_WIDTH  = 31'd52428800;
    localparam t_len  RST_WORLD_HEIGHT = 31'd39321600;

    // One body as it enters the block.
    typedef struct packed {
        t_val  pos_x;
        t_val  pos_y;
        t_val  vel_x;
        t_val  vel_y;
        t_len  radius;
        t_frac bounce;
    } t_body;

    // Integrated body plus the once-reflected velocities.
    typedef struct packed {
        t_val  pos_x;
        t_val  pos_y;
        t_val  vel_x;
        t_val  vel_y;
        t_val  rfl_x;
        t_val  rfl_y;
        t_len  radius;
        t_frac bounce;
    } t_mid;

    localparam t_wide SAT_MAX = t_wide'((64'sd1 <<< (VALUE_W - 1)) - 64'sd1);
    localparam t_wide SAT_MIN = t_wide'(-((64'sd1 <<< (VALUE_W - 1))));

    function automatic t_val sat_val(input t_wide v);
        t_val res;
        if (v > SAT_MAX) begin
            res = SAT_MAX[VALUE_W-1:0];
        end else if (v < SAT_MIN) begin
            res = SAT_MIN[VALUE_W-1:0];
        end else begin
            res = v[VALUE_W-1:0];
        end
        return res;
    endfunction

    // Signed value times an unsigned 16-bit fraction.
    function automatic t_prod mul_frac(input t_val v, input t_frac f);
        t_prod a;
        t_prod b;
        a = t_prod'(v);
        b = t_prod'($signed({1'b0, f}));
        return a * b;
    endfunction

    // Floor of a Q.16 product back to the value scale.
    function automatic t_wide scaled_dt(input t_prod p);
        return t_wide'(p >>> FRAC_W);
    endfunction

    // Floor of the negated Q1.15 product: the reflection before saturation.
    function automatic t_wide neg_q15(input t_prod p);
        logic signed [PROD_W:0] n;
        n = {p[PROD_W-1], p};
        n = -n;
        return t_wide'(n >>> BF_FRAC);
    endfunction

endpackage

// ----- sv/cbe_cfg_regs.sv -----
module cbe_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cbe_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cbe_pkg::VALUE_W-1:0]      i_cfg_data,
    output cbe_pkg::t_cfg                    o_cfg
);

    cbe_pkg::t_cfg r_cfg;
    cbe_pkg::t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (cbe_pkg::t_cfg_idx'(i_cfg_index))
                cbe_pkg::CFG_GRAVITY_X: begin
                    n_cfg.gravity_x = i_cfg_data;
                end
                cbe_pkg::CFG_GRAVITY_Y: begin
                    n_cfg.gravity_y = i_cfg_data;
                end
                cbe_pkg::CFG_TIME_STEP: begin
                    n_cfg.time_step = i_cfg_data[cbe_pkg::FRAC_W-1:0];
                end
                cbe_pkg::CFG_WORLD_WIDTH: begin
                    n_cfg.world_width = i_cfg_data[cbe_pkg::LEN_W-1:0];
                end
                cbe_pkg::CFG_WORLD_HEIGHT: begin
                    n_cfg.world_height = i_cfg_data[cbe_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_x    <= cbe_pkg::RST_GRAVITY_X;
            r_cfg.gravity_y    <= cbe_pkg::RST_GRAVITY_Y;
            r_cfg.time_step    <= cbe_pkg::RST_TIME_STEP;
            r_cfg.world_width  <= cbe_pkg::RST_WORLD_WIDTH;
            r_cfg.world_height <= cbe_pkg::RST_WORLD_HEIGHT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// ----- sv/cbe_integrate.sv -----
module cbe_integrate (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cbe_pkg::t_cfg  i_cfg,
    input  logic           i_valid,
    output logic           o_ready,
    input  cbe_pkg::t_body i_body,
    output logic           o_valid,
    input  logic           i_ready,
    output cbe_pkg::t_mid  o_mid
);

    // Stage 1: gravity times dt. Stage 2: velocity update.
    // Stage 3: velocity times dt and times restitution. Stage 4: position and first reflection.
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v;
    logic en1, en2, en3, en4;

    cbe_pkg::t_body r_s1_body, n_s1_body;
    cbe_pkg::t_prod r_s1_gx, n_s1_gx, r_s1_gy, n_s1_gy;
    cbe_pkg::t_body r_s2_body, n_s2_body;
    cbe_pkg::t_body r_s3_body, n_s3_body;
    cbe_pkg::t_prod r_s3_mdx, n_s3_mdx, r_s3_mdy, n_s3_mdy;
    cbe_pkg::t_prod r_s3_mbx, n_s3_mbx, r_s3_mby, n_s3_mby;
    cbe_pkg::t_mid  r_s4_mid, n_s4_mid;

    // A stage moves when it is empty or when the stage after it moves.
    assign en4     = !r_s4_v || i_ready;
    assign en3     = !r_s3_v || en4;
    assign en2     = !r_s2_v || en3;
    assign en1     = !r_s1_v || en2;
    assign o_ready = en1;
    assign o_valid = r_s4_v;
    assign o_mid   = r_s4_mid;

    always_comb begin
        n_s1_body = i_body;
        n_s1_gx   = cbe_pkg::mul_frac(i_cfg.gravity_x, i_cfg.time_step);
        n_s1_gy   = cbe_pkg::mul_frac(i_cfg.gravity_y, i_cfg.time_step);

        n_s2_body       = r_s1_body;
        n_s2_body.vel_x = cbe_pkg::sat_val(cbe_pkg::t_wide'(r_s1_body.vel_x)
                                           + cbe_pkg::scaled_dt(r_s1_gx));
        n_s2_body.vel_y = cbe_pkg::sat_val(cbe_pkg::t_wide'(r_s1_body.vel_y)
                                           + cbe_pkg::scaled_dt(r_s1_gy));

        n_s3_body = r_s2_body;
        n_s3_mdx  = cbe_pkg::mul_frac(r_s2_body.vel_x, i_cfg.time_step);
        n_s3_mdy  = cbe_pkg::mul_frac(r_s2_body.vel_y, i_cfg.time_step);
        n_s3_mbx  = cbe_pkg::mul_frac(r_s2_body.vel_x, r_s2_body.bounce);
        n_s3_mby  = cbe_pkg::mul_frac(r_s2_body.vel_y, r_s2_body.bounce);

        n_s4_mid.pos_x  = cbe_pkg::sat_val(cbe_pkg::t_wide'(r_s3_body.pos_x)
                                           + cbe_pkg::scaled_dt(r_s3_mdx));
        n_s4_mid.pos_y  = cbe_pkg::sat_val(cbe_pkg::t_wide'(r_s3_body.pos_y)
                                           + cbe_pkg::scaled_dt(r_s3_mdy));
        n_s4_mid.vel_x  = r_s3_body.vel_x;
        n_s4_mid.vel_y  = r_s3_body.vel_y;
        n_s4_mid.rfl_x  = cbe_pkg::sat_val(cbe_pkg::neg_q15(r_s3_mbx));
        n_s4_mid.rfl_y  = cbe_pkg::sat_val(cbe_pkg::neg_q15(r_s3_mby));
        n_s4_mid.radius = r_s3_body.radius;
        n_s4_mid.bounce = r_s3_body.bounce;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
            r_s4_v <= 1'b0;
        end else begin
            if (en1) begin
                r_s1_v <= i_valid;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (en3) begin
                r_s3_v <= r_s2_v;
            end
            if (en4) begin
                r_s4_v <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_body <= n_s1_body;
            r_s1_gx   <= n_s1_gx;
            r_s1_gy   <= n_s1_gy;
        end
        if (en2) begin
            r_s2_body <= n_s2_body;
        end
        if (en3) begin
            r_s3_body <= n_s3_body;
            r_s3_mdx  <= n_s3_mdx;
            r_s3_mdy  <= n_s3_mdy;
            r_s3_mbx  <= n_s3_mbx;
            r_s3_mby  <= n_s3_mby;
        end
        if (en4) begin
            r_s4_mid <= n_s4_mid;
        end
    end

endmodule

// ----- sv/cbe_collide.sv -----
module cbe_collide (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cbe_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    output logic          o_ready,
    input  cbe_pkg::t_mid i_mid,
    output logic          o_valid,
    input  logic          i_ready,
    output cbe_pkg::t_val o_pos_x,
    output cbe_pkg::t_val o_pos_y,
    output cbe_pkg::t_val o_vel_x,
    output cbe_pkg::t_val o_vel_y
);

    // Stage 5: wall tests and the second reflection product.
    // Stage 6: second reflection, clamp and selection; this is the output register.
    logic r_s5_v, r_s6_v;
    logic en5, en6;

    cbe_pkg::t_mid  r_s5_mid;
    logic           r_s5_lo_x, n_s5_lo_x, r_s5_hi_x, n_s5_hi_x;
    logic           r_s5_lo_y, n_s5_lo_y, r_s5_hi_y, n_s5_hi_y;
    cbe_pkg::t_prod r_s5_m2x, n_s5_m2x, r_s5_m2y, n_s5_m2y;

    cbe_pkg::t_val  r_s6_pos_x, n_s6_pos_x, r_s6_pos_y, n_s6_pos_y;
    cbe_pkg::t_val  r_s6_vel_x, n_s6_vel_x, r_s6_vel_y, n_s6_vel_y;

    cbe_pkg::t_wide rad_w;
    cbe_pkg::t_wide lo_diff_x, lo_diff_y, hi_sum_x, hi_sum_y;
    cbe_pkg::t_val  rad_v, rfl2_x, rfl2_y;

    assign en6     = !r_s6_v || i_ready;
    assign en5     = !r_s5_v || en6;
    assign o_ready = en5;
    assign o_valid = r_s6_v;
    assign o_pos_x = r_s6_pos_x;
    assign o_pos_y = r_s6_pos_y;
    assign o_vel_x = r_s6_vel_x;
    assign o_vel_y = r_s6_vel_y;

    always_comb begin
        // All four tests look at the integrated position before any clamp.
        rad_w     = cbe_pkg::t_wide'(i_mid.radius);
        lo_diff_x = cbe_pkg::t_wide'(i_mid.pos_x) - rad_w;
        lo_diff_y = cbe_pkg::t_wide'(i_mid.pos_y) - rad_w;
        hi_sum_x  = cbe_pkg::t_wide'(i_mid.pos_x) + rad_w;
        hi_sum_y  = cbe_pkg::t_wide'(i_mid.pos_y) + rad_w;
        n_s5_lo_x = lo_diff_x[cbe_pkg::SAT_IN_W-1];
        n_s5_lo_y = lo_diff_y[cbe_pkg::SAT_IN_W-1];
        n_s5_hi_x = hi_sum_x > cbe_pkg::t_wide'(i_cfg.world_width);
        n_s5_hi_y = hi_sum_y > cbe_pkg::t_wide'(i_cfg.world_height);
        n_s5_m2x  = cbe_pkg::mul_frac(i_mid.rfl_x, i_mid.bounce);
        n_s5_m2y  = cbe_pkg::mul_frac(i_mid.rfl_y, i_mid.bounce);
    end

    always_comb begin
        rad_v  = cbe_pkg::t_val'(r_s5_mid.radius);
        rfl2_x = cbe_pkg::sat_val(cbe_pkg::neg_q15(r_s5_m2x));
        rfl2_y = cbe_pkg::sat_val(cbe_pkg::neg_q15(r_s5_m2y));

        // The far wall wins the position when both walls are hit.
        if (r_s5_hi_x) begin
            n_s6_pos_x = cbe_pkg::t_val'(i_cfg.world_width) - rad_v;
        end else if (r_s5_lo_x) begin
            n_s6_pos_x = rad_v;
        end else begin
            n_s6_pos_x = r_s5_mid.pos_x;
        end
        if (r_s5_hi_y) begin
            n_s6_pos_y = cbe_pkg::t_val'(i_cfg.world_height) - rad_v;
        end else if (r_s5_lo_y) begin
            n_s6_pos_y = rad_v;
        end else begin
            n_s6_pos_y = r_s5_mid.pos_y;
        end

        // Two hits reflect the velocity twice.
        if (r_s5_lo_x && r_s5_hi_x) begin
            n_s6_vel_x = rfl2_x;
        end else if (r_s5_lo_x || r_s5_hi_x) begin
            n_s6_vel_x = r_s5_mid.rfl_x;
        end else begin
            n_s6_vel_x = r_s5_mid.vel_x;
        end
        if (r_s5_lo_y && r_s5_hi_y) begin
            n_s6_vel_y = rfl2_y;
        end else if (r_s5_lo_y || r_s5_hi_y) begin
            n_s6_vel_y = r_s5_mid.rfl_y;
        end else begin
            n_s6_vel_y = r_s5_mid.vel_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_v <= 1'b0;
            r_s6_v <= 1'b0;
        end else begin
            if (en5) begin
                r_s5_v <= i_valid;
            end
            if (en6) begin
                r_s6_v <= r_s5_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r_s5_mid  <= i_mid;
            r_s5_lo_x <= n_s5_lo_x;
            r_s5_hi_x <= n_s5_hi_x;
            r_s5_lo_y <= n_s5_lo_y;
            r_s5_hi_y <= n_s5_hi_y;
            r_s5_m2x  <= n_s5_m2x;
            r_s5_m2y  <= n_s5_m2y;
        end
        if (en6) begin
            r_s6_pos_x <= n_s6_pos_x;
            r_s6_pos_y <= n_s6_pos_y;
            r_s6_vel_x <= n_s6_vel_x;
            r_s6_vel_y <= n_s6_vel_y;
        end
    end

endmodule

// ----- sv/circle_body_euler_step_bounce.sv -----
// An accepted item passes through the stage registers s1 to s6 in order; s6 is the output
// register. Throughput: one item per cycle while the output is taken; six pipeline
// stages, each about one multiplier or one wide add with saturation deep.
// Each stage moves when it is empty or the stage after it moves, so bubbles fill in.
// Reset (synchronous, active low) empties the pipeline and restores the register defaults.
module circle_body_euler_step_bounce (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [cbe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [cbe_pkg::VALUE_W-1:0]   i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cbe_pkg::t_val                 i_pos_x,
    input  cbe_pkg::t_val                 i_pos_y,
    input  cbe_pkg::t_val                 i_vel_x,
    input  cbe_pkg::t_val                 i_vel_y,
    input  cbe_pkg::t_len                 i_body_radius,
    input  cbe_pkg::t_frac                i_bounce_factor,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cbe_pkg::t_val                 o_new_pos_x,
    output cbe_pkg::t_val                 o_new_pos_y,
    output cbe_pkg::t_val                 o_new_vel_x,
    output cbe_pkg::t_val                 o_new_vel_y
);

    cbe_pkg::t_cfg  cfg;
    cbe_pkg::t_body body;
    cbe_pkg::t_mid  mid;
    logic           mid_valid;
    logic           mid_ready;

    assign body.pos_x  = i_pos_x;
    assign body.pos_y  = i_pos_y;
    assign body.vel_x  = i_vel_x;
    assign body.vel_y  = i_vel_y;
    assign body.radius = i_body_radius;
    assign body.bounce = i_bounce_factor;

    cbe_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    cbe_integrate u_integrate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_body  (body),
        .o_valid (mid_valid),
        .i_ready (mid_ready),
        .o_mid   (mid)
    );

    cbe_collide u_collide (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (mid_valid),
        .o_ready (mid_ready),
        .i_mid   (mid),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_pos_x (o_new_pos_x),
        .o_pos_y (o_new_pos_y),
        .o_vel_x (o_new_vel_x),
        .o_vel_y (o_new_vel_y)
    );

endmodule

// ----- sv/cbe_checker.sv -----
`include "assert_macros.svh"

module cbe_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input cbe_pkg::t_val o_new_pos_x,
    input cbe_pkg::t_val o_new_pos_y,
    input cbe_pkg::t_val o_new_vel_x,
    input cbe_pkg::t_val o_new_vel_y
);

    logic [4*cbe_pkg::VALUE_W-1:0] out_bus;
    logic                          out_stall;

    assign out_bus   = {o_new_pos_x, o_new_pos_y, o_new_vel_x, o_new_vel_y};
    assign out_stall = o_out_valid && !i_out_ready;

    // Reset empties the output register.
    `CBE_ASSERT_NEXT(a_rst_empties_out, i_clk, 1'b0, !i_rst_n, !o_out_valid)

    // A result that is not taken stays put.
    `CBE_ASSERT_NEXT(a_out_hold, i_clk, !i_rst_n, out_stall, o_out_valid && $stable(out_bus))

    // With the output register empty nothing can block the input.
    `CBE_ASSERT_IMPL(a_empty_accepts, i_clk, !i_rst_n, !o_out_valid, o_in_ready)

    // A result appearing after a gap must trace back to an item accepted at the input.
    `CBE_ASSERT_IMPL(a_latency, i_clk, !i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 6))

endmodule

bind circle_body_euler_step_bounce cbe_checker u_cbe_checker (.*);

// ----- verif/tb_circle_body_euler_step_bounce.sv -----
`timescale 1ns / 100ps

module tb_circle_body_euler_step_bounce;

    localparam int     ONE          = 1 << cbe_pkg::FRAC_W;
    localparam int     UNITY        = 1 << cbe_pkg::BF_FRAC;
    localparam longint VAL_MAX      = (64'sd1 <<< (cbe_pkg::VALUE_W - 1)) - 1;
    localparam longint VAL_MIN      = -VAL_MAX - 1;
    localparam int     N_PHASES     = 12;
    localparam int     PHASE_LEN    = 147;
    localparam int     DRAIN_CYCLES = 12;

    typedef struct packed {
        cbe_pkg::t_val pos_x;
        cbe_pkg::t_val pos_y;
        cbe_pkg::t_val vel_x;
        cbe_pkg::t_val vel_y;
    } t_motion;

    typedef struct {
        cbe_pkg::t_body body;
        bit             known;
        t_motion        motion;
    } t_dir_row;

    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          i_cfg_valid     = 1'b0;
    logic                          o_cfg_ready;
    logic [cbe_pkg::CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [cbe_pkg::VALUE_W-1:0]   i_cfg_data      = '0;
    logic                          i_in_valid      = 1'b0;
    logic                          o_in_ready;
    cbe_pkg::t_val                 i_pos_x         = '0;
    cbe_pkg::t_val                 i_pos_y         = '0;
    cbe_pkg::t_val                 i_vel_x         = '0;
    cbe_pkg::t_val                 i_vel_y         = '0;
    cbe_pkg::t_len                 i_body_radius   = '0;
    cbe_pkg::t_frac                i_bounce_factor = '0;
    logic                          o_out_valid;
    logic                          i_out_ready     = 1'b0;
    cbe_pkg::t_val                 o_new_pos_x;
    cbe_pkg::t_val                 o_new_pos_y;
    cbe_pkg::t_val                 o_new_vel_x;
    cbe_pkg::t_val                 o_new_vel_y;

    cbe_pkg::t_cfg cfg_model;
    t_motion       awaited_steps[$];
    t_dir_row      dir_rows[$];
    int            errors     = 0;
    bit            steady     = 1'b0;
    int            stall_left = 0;

    circle_body_euler_step_bounce u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_vel_x         (i_vel_x),
        .i_vel_y         (i_vel_y),
        .i_body_radius   (i_body_radius),
        .i_bounce_factor (i_bounce_factor),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_new_pos_x     (o_new_pos_x),
        .o_new_pos_y     (o_new_pos_y),
        .o_new_vel_x     (o_new_vel_x),
        .o_new_vel_y     (o_new_vel_y)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #(4_000_000);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic longint clamp_val(input longint v);
        if (v > VAL_MAX) begin
            return VAL_MAX;
        end
        if (v < VAL_MIN) begin
            return VAL_MIN;
        end
        return v;
    endfunction

    // Velocity times -restitution, floored back to Q16.16.
    function automatic longint reflect_vel(input longint v, input longint bf);
        return clamp_val((-(v * bf)) >>> cbe_pkg::BF_FRAC);
    endfunction

    function automatic t_motion advance_body(input cbe_pkg::t_body b);
        longint  gx, gy, dt, w, h, r, bf;
        longint  px, py, vx, vy, cx, cy;
        t_motion m;
        gx = longint'(cfg_model.gravity_x);
        gy = longint'(cfg_model.gravity_y);
        dt = longint'(cfg_model.time_step);
        w  = longint'(cfg_model.world_width);
        h  = longint'(cfg_model.world_height);
        r  = longint'(b.radius);
        bf = longint'(b.bounce);
        px = longint'(b.pos_x);
        py = longint'(b.pos_y);
        vx = longint'(b.vel_x);
        vy = longint'(b.vel_y);

        // Semi-implicit: the position moves with the already updated velocity.
        vx = clamp_val(vx + ((gx * dt) >>> cbe_pkg::FRAC_W));
        vy = clamp_val(vy + ((gy * dt) >>> cbe_pkg::FRAC_W));
        px = clamp_val(px + ((vx * dt) >>> cbe_pkg::FRAC_W));
        py = clamp_val(py + ((vy * dt) >>> cbe_pkg::FRAC_W));

        // All four wall tests look at the unclamped position.
        cx = px;
        cy = py;
        if (cx - r < 0) begin
            px = clamp_val(r);
            vx = reflect_vel(vx, bf);
        end
        if (cx + r > w) begin
            px = clamp_val(w - r);
            vx = reflect_vel(vx, bf);
        end
        if (cy - r < 0) begin
            py = clamp_val(r);
            vy = reflect_vel(vy, bf);
        end
        if (cy + r > h) begin
            py = clamp_val(h - r);
            vy = reflect_vel(vy, bf);
        end

        m.pos_x = px[cbe_pkg::VALUE_W-1:0];
        m.pos_y = py[cbe_pkg::VALUE_W-1:0];
        m.vel_x = vx[cbe_pkg::VALUE_W-1:0];
        m.vel_y = vy[cbe_pkg::VALUE_W-1:0];
        return m;
    endfunction

    function automatic longint rand_between(input longint lo, input longint hi);
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            return 0;
        end
        if (sel < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Coordinate close to one of the two walls of an axis, or anywhere between them.
    function automatic longint near_wall(input longint lim, input longint r);
        longint span;
        span = r + 4 * ONE;
        case ($urandom_range(0, 3))
            0: return rand_between(-span, span);
            1: return lim + rand_between(-span, span);
            default: return rand_between(0, lim);
        endcase
    endfunction

    function automatic cbe_pkg::t_val pick_extreme();
        case ($urandom_range(0, 4))
            0: return {1'b0, {(cbe_pkg::VALUE_W-1){1'b1}}};
            1: return {1'b1, {(cbe_pkg::VALUE_W-1){1'b0}}};
            2: return '0;
            3: return '1;
            default: return 1;
        endcase
    endfunction

    function automatic cbe_pkg::t_body make_body();
        cbe_pkg::t_body b;
        longint         r;
        int             kind;
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
            r = rand_between(0, 8 * ONE);
            b.pos_x  = cbe_pkg::t_val'(near_wall(cfg_model.world_width, r));
            b.pos_y  = cbe_pkg::t_val'(near_wall(cfg_model.world_height, r));
            b.vel_x  = cbe_pkg::t_val'(rand_between(-64 * ONE, 64 * ONE));
            b.vel_y  = cbe_pkg::t_val'(rand_between(-64 * ONE, 64 * ONE));
            b.radius = cbe_pkg::t_len'(r);
            if ($urandom_range(0, 3) != 0) begin
                b.bounce = cbe_pkg::t_frac'($urandom_range(0, UNITY));
            end else begin
                b.bounce = cbe_pkg::t_frac'($urandom);
            end
        end else if (kind < 17) begin
            b.pos_x = pick_extreme();
            b.pos_y = pick_extreme();
            b.vel_x = pick_extreme();
            b.vel_y = pick_extreme();
            case ($urandom_range(0, 2))
                0: b.radius = '0;
                1: b.radius = '1;
                default: b.radius = cbe_pkg::t_len'(1);
            endcase
            case ($urandom_range(0, 3))
                0: b.bounce = '0;
                1: b.bounce = cbe_pkg::t_frac'(UNITY);
                2: b.bounce = '1;
                default: b.bounce = cbe_pkg::t_frac'(1);
            endcase
        end else begin
            b.pos_x  = $urandom;
            b.pos_y  = $urandom;
            b.vel_x  = $urandom;
            b.vel_y  = $urandom;
            b.radius = cbe_pkg::t_len'($urandom);
            b.bounce = cbe_pkg::t_frac'($urandom);
        end
        return b;
    endfunction

    function automatic void add_row(input cbe_pkg::t_val px, input cbe_pkg::t_val py,
                                    input cbe_pkg::t_val vx, input cbe_pkg::t_val vy,
                                    input int r, input int bf,
                                    input bit known = 1'b0,
                                    input cbe_pkg::t_val e_px = '0,
                                    input cbe_pkg::t_val e_py = '0,
                                    input cbe_pkg::t_val e_vx = '0,
                                    input cbe_pkg::t_val e_vy = '0);
        t_dir_row row;
        row.body   = '{pos_x: px, pos_y: py, vel_x: vx, vel_y: vy,
                       radius: cbe_pkg::t_len'(r), bounce: cbe_pkg::t_frac'(bf)};
        row.known  = known;
        row.motion = '{pos_x: e_px, pos_y: e_py, vel_x: e_vx, vel_y: e_vy};
        dir_rows.push_back(row);
    endfunction

    function automatic void compare_field(input string name, input cbe_pkg::t_val want,
                                          input cbe_pkg::t_val got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d (%h), got %0d (%h)",
                     $time, name, want, want, got, got);
            errors++;
        end
    endfunction

    task automatic write_reg(input logic [cbe_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cbe_pkg::VALUE_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (cbe_pkg::t_cfg_idx'(idx))
            cbe_pkg::CFG_GRAVITY_X:    cfg_model.gravity_x    = data;
            cbe_pkg::CFG_GRAVITY_Y:    cfg_model.gravity_y    = data;
            cbe_pkg::CFG_TIME_STEP:    cfg_model.time_step    = data[cbe_pkg::FRAC_W-1:0];
            cbe_pkg::CFG_WORLD_WIDTH:  cfg_model.world_width  = data[cbe_pkg::LEN_W-1:0];
            cbe_pkg::CFG_WORLD_HEIGHT: cfg_model.world_height = data[cbe_pkg::LEN_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Valid stays high from one item to the next unless a gap is drawn.
    task automatic send_body(input cbe_pkg::t_body b, input bit known, input t_motion typed);
        int      gap;
        t_motion m;
        m   = known ? typed : advance_body(b);
        gap = steady ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_pos_x         <= b.pos_x;
        i_pos_y         <= b.pos_y;
        i_vel_x         <= b.vel_x;
        i_vel_y         <= b.vel_y;
        i_body_radius   <= b.radius;
        i_bounce_factor <= b.bounce;
        do @(posedge i_clk); while (!o_in_ready);
        awaited_steps.push_back(m);
    endtask

    task automatic run_bodies(input int n);
        for (int i = 0; i < n; i++) begin
            send_body(make_body(), 1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (awaited_steps.size() != 0) @(posedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            i_out_ready <= 1'b1;
            if (!steady) begin
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_motion exp_m;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_steps.size() == 0) begin
                $display("%0t: unexpected item: pos %0d,%0d vel %0d,%0d", $time,
                         o_new_pos_x, o_new_pos_y, o_new_vel_x, o_new_vel_y);
                errors++;
            end else begin
                exp_m = awaited_steps.pop_front();
                compare_field("new_pos_x", exp_m.pos_x, o_new_pos_x);
                compare_field("new_pos_y", exp_m.pos_y, o_new_pos_y);
                compare_field("new_vel_x", exp_m.vel_x, o_new_vel_x);
                compare_field("new_vel_y", exp_m.vel_y, o_new_vel_y);
            end
        end
    end

    initial begin
        logic [cbe_pkg::VALUE_W-1:0]   val;
        logic [cbe_pkg::CFG_IDX_W-1:0] spare_idx;
        int                            sel;

        cfg_model.gravity_x    = cbe_pkg::RST_GRAVITY_X;
        cfg_model.gravity_y    = cbe_pkg::RST_GRAVITY_Y;
        cfg_model.time_step    = cbe_pkg::RST_TIME_STEP;
        cfg_model.world_width  = cbe_pkg::RST_WORLD_WIDTH;
        cfg_model.world_height = cbe_pkg::RST_WORLD_HEIGHT;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Bodies under the power-on settings.
        run_bodies(40);
        wait_idle();

        // With no gravity and a zero time step only the wall logic acts.
        write_reg(cbe_pkg::CFG_GRAVITY_X, '0);
        write_reg(cbe_pkg::CFG_GRAVITY_Y, '0);
        write_reg(cbe_pkg::CFG_TIME_STEP, '0);
        write_reg(cbe_pkg::CFG_WORLD_WIDTH, 100 * ONE);
        write_reg(cbe_pkg::CFG_WORLD_HEIGHT, 80 * ONE);
        sel = $urandom_range(int'(cbe_pkg::CFG_WORLD_HEIGHT) + 1,
                             (1 << cbe_pkg::CFG_IDX_W) - 1);
        spare_idx = sel[cbe_pkg::CFG_IDX_W-1:0];
        write_reg(spare_idx, $urandom);

        add_row(50 * ONE, 40 * ONE, 3 * ONE, -2 * ONE, 5 * ONE, UNITY,
                1'b1, 50 * ONE, 40 * ONE, 3 * ONE, -2 * ONE);
        add_row(2 * ONE, 40 * ONE, -3 * ONE, 0, 5 * ONE, UNITY,
                1'b1, 5 * ONE, 40 * ONE, 3 * ONE, 0);
        add_row(98 * ONE, 40 * ONE, 4 * ONE, ONE, 5 * ONE, UNITY / 2,
                1'b1, 95 * ONE, 40 * ONE, -2 * ONE, ONE);
        add_row(50 * ONE, ONE, 0, -6 * ONE, 3 * ONE, UNITY,
                1'b1, 50 * ONE, 3 * ONE, 0, 6 * ONE);
        add_row(50 * ONE, 79 * ONE, 0, 8 * ONE, 3 * ONE, 0,
                1'b1, 50 * ONE, 77 * ONE, 0, 0);
        add_row(ONE, ONE, -ONE, -ONE, 2 * ONE, UNITY,
                1'b1, 2 * ONE, 2 * ONE, ONE, ONE);
        // Diameter wider than the world: both walls of each axis hit.
        add_row(50 * ONE, 40 * ONE, 5 * ONE, 0, 60 * ONE, UNITY,
                1'b1, 40 * ONE, 20 * ONE, 5 * ONE, 0);
        // Exactly touching a wall is not a hit.
        add_row(5 * ONE, 40 * ONE, -ONE, ONE, 5 * ONE, UNITY,
                1'b1, 5 * ONE, 40 * ONE, -ONE, ONE);
        add_row(95 * ONE, 75 * ONE, ONE, ONE, 5 * ONE, UNITY,
                1'b1, 95 * ONE, 75 * ONE, ONE, ONE);
        add_row(2 * ONE, 40 * ONE, 32'h8000_0000, 0, 5 * ONE, UNITY,
                1'b1, 5 * ONE, 40 * ONE, 32'h7fff_ffff, 0);
        add_row(32'h7fff_ffff, 32'h8000_0000, 0, 0, 0, UNITY,
                1'b1, 100 * ONE, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 1'b1, 0, 0, 0, 0);
        add_row(2 * ONE, 40 * ONE, -ONE, 0, 5 * ONE, 32'h0000_ffff);
        add_row(2 * ONE, 40 * ONE, 32'h8000_0000, 0, 5 * ONE, 32'h0000_ffff);
        add_row(98 * ONE, 40 * ONE, 32'h7fff_ffff, 0, 5 * ONE, UNITY);
        add_row(98 * ONE, 40 * ONE, 32'h7fff_ffff, 0, 5 * ONE, 32'h0000_ffff);
        add_row(0, 0, 0, 0, 32'h7fff_ffff, UNITY);
        add_row(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h0000_ffff);
        // Reflection of tiny velocities shows the floor rounding.
        add_row(2 * ONE, 40 * ONE, -1, 0, 5 * ONE, 1);
        add_row(2 * ONE, 40 * ONE, 1, 0, 5 * ONE, 1);

        foreach (dir_rows[i]) begin
            send_body(dir_rows[i].body, dir_rows[i].known, dir_rows[i].motion);
        end
        wait_idle();

        // Phase 1 sets every register to its top value, phase 2 to its bottom one.
        for (int p = 1; p <= N_PHASES; p++) begin
            steady = (p % 4 == 0);
            for (int k = cbe_pkg::CFG_GRAVITY_X; k <= cbe_pkg::CFG_WORLD_HEIGHT; k++) begin
                if (p > 2 && $urandom_range(0, 4) == 0) begin
                    continue;
                end
                sel = $urandom_range(0, 9);
                case (cbe_pkg::t_cfg_idx'(k))
                    cbe_pkg::CFG_GRAVITY_X, cbe_pkg::CFG_GRAVITY_Y: begin
                        if (p == 1) begin
                            val = 32'h7fff_ffff;
                        end else if (p == 2) begin
                            val = 32'h8000_0000;
                        end else begin
                            case (sel)
                                0: val = 32'h7fff_ffff;
                                1: val = 32'h8000_0000;
                                2: val = $urandom;
                                default: val = 32'(rand_between(-32 * ONE, 32 * ONE));
                            endcase
                        end
                    end
                    cbe_pkg::CFG_TIME_STEP: begin
                        if (p == 1) begin
                            val = '1;
                        end else if (p == 2) begin
                            val = '0;
                        end else begin
                            case (sel)
                                0: val = 32'h0000_ffff;
                                1: val = '0;
                                2: val = $urandom;
                                default: val = $urandom_range(1, 4096);
                            endcase
                        end
                    end
                    default: begin
                        if (p == 1) begin
                            val = '1;
                        end else if (p == 2) begin
                            val = '0;
                        end else begin
                            case (sel)
                                0: val = 32'h7fff_ffff;
                                1: val = '0;
                                2: val = $urandom;
                                default: val = $urandom_range(20, 2000) * ONE;
                            endcase
                        end
                    end
                endcase
                write_reg(k[cbe_pkg::CFG_IDX_W-1:0], val);
            end
            if (p % 3 == 0) begin
                sel = $urandom_range(int'(cbe_pkg::CFG_WORLD_HEIGHT) + 1,
                                     (1 << cbe_pkg::CFG_IDX_W) - 1);
                spare_idx = sel[cbe_pkg::CFG_IDX_W-1:0];
                write_reg(spare_idx, $urandom);
            end
            run_bodies(PHASE_LEN);
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
